[design/pfa_pkg.sv]
package pfa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TIME_W         = 32;
    localparam int TIME_FRAC      = 24;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 3;

    localparam logic [STATUS_W-1:0] ST_COMPUTED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_COMPUTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd6;

    localparam logic [TIME_W-1:0] DT_MIN = 32'd2;

    // datapath operation codes
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_P   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_KI  = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_I   = 4'd4;
    localparam logic [OP_W-1:0] OP_CLAMP_I = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_FF  = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_D   = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd9;
    localparam logic [OP_W-1:0] OP_SUM     = 4'd10;
    localparam logic [OP_W-1:0] OP_CLEAR   = 4'd11;
    localparam logic [OP_W-1:0] OP_SKIP    = 4'd12;
    localparam logic [OP_W-1:0] OP_MUL_IH  = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } pfa_cmd_t;

    typedef struct packed {
        logic first;
        logic dt_small;
        logic div_last;
    } pfa_stat_t;

endpackage

[design/pfa_datapath.sv]
module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfa_cmd_t                     cmd,
    output pfa_stat_t                    stat,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_idx,
    input  logic [DATA_WIDTH-1:0]        cfg_data,
    input  logic                         in_load,
    input  logic signed [DATA_WIDTH-1:0] sp_in,
    input  logic signed [DATA_WIDTH-1:0] fb_in,
    input  logic signed [DATA_WIDTH-1:0] ff_in,
    input  logic [TIME_W-1:0]            dt_in,
    output logic signed [DATA_WIDTH-1:0] drive,
    output logic [STATUS_W-1:0]          status
);
    localparam int EW  = DATA_WIDTH + 1;
    localparam int DW  = DATA_WIDTH + 2;
    localparam int PW  = DATA_WIDTH + DW;
    localparam int NW  = PW + TIME_FRAC - FRAC_BITS;
    localparam int ACW = NW + 4;
    localparam int CW  = $clog2(NW + 1);
    localparam int KW  = DATA_WIDTH + TIME_W - TIME_FRAC;
    localparam int KL  = KW / 2;

    logic signed [DATA_WIDTH-1:0] gp_reg, gi_reg, gd_reg, gf_reg, omin_reg, omax_reg;
    logic [DATA_WIDTH-2:0]        wl_reg;
    logic signed [DATA_WIDTH-1:0] integ_reg, integ_next;
    logic signed [EW-1:0]         prev_reg;
    logic                         first_reg;
    logic signed [DATA_WIDTH-1:0] sp_reg, fb_reg, ff_reg;
    logic [TIME_W-1:0]            dt_reg;
    logic signed [EW-1:0]         e_reg;
    logic signed [ACW-1:0]        sum_reg;
    logic signed [KW-1:0]         k_reg;
    logic signed [ACW-1:0]        acc_new_reg;
    logic [NW-1:0]                quo_reg;
    logic [TIME_W:0]              rem_reg;
    logic                         dneg_reg;
    logic [CW-1:0]                cnt_reg;
    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic [STATUS_W-1:0]          status_reg;

    logic signed [ACW-1:0]        lim_p, lim_n, acc_c, omax_x, omin_x, s1, s2, dq;
    logic signed [EW:0]           diff;
    logic signed [PW-1:0]         dprod;
    logic [TIME_W+1:0]            trial;

    assign diff   = EW'(e_reg) - EW'(prev_reg) + (EW+1)'(0);
    assign lim_p  = ACW'($signed({1'b0, wl_reg}));
    assign lim_n  = -lim_p;
    assign omax_x = ACW'(omax_reg);
    assign omin_x = ACW'(omin_reg);
    assign dprod  = PW'(gd_reg) * PW'(diff);
    assign trial  = {rem_reg, quo_reg[NW-1]} - {2'b0, dt_reg};

    always_comb
    begin
        acc_c = acc_new_reg;
        if (acc_c > lim_p)
        begin
            acc_c = lim_p;
        end
        if (acc_c < lim_n)
        begin
            acc_c = lim_n;
        end
        dq = dneg_reg ? -ACW'($signed({1'b0, quo_reg})) : ACW'($signed({1'b0, quo_reg}));
        s1 = sum_reg + dq;
        s2 = s1;
        if (s2 > omax_x)
        begin
            s2 = omax_x;
        end
        if (s2 < omin_x)
        begin
            s2 = omin_x;
        end
    end

    assign stat.first    = first_reg;
    assign stat.dt_small = dt_reg < DT_MIN;
    assign stat.div_last = cnt_reg == CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg     <= '0;
            gi_reg     <= '0;
            gd_reg     <= '0;
            gf_reg     <= '0;
            wl_reg     <= (DATA_WIDTH-1)'(3) << FRAC_BITS;
            omin_reg   <= -(DATA_WIDTH'(1) << FRAC_BITS);
            omax_reg   <= DATA_WIDTH'(1) << FRAC_BITS;
            integ_reg  <= '0;
            prev_reg   <= '0;
            first_reg  <= 1'b1;
            cnt_reg    <= '0;
            status_reg <= ST_COMPUTED;
            drive_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_GAIN_P:  gp_reg   <= cfg_data;
                    REG_GAIN_I:  gi_reg   <= cfg_data;
                    REG_GAIN_D:  gd_reg   <= cfg_data;
                    REG_GAIN_FF: gf_reg   <= cfg_data;
                    REG_WINDUP:  wl_reg   <= cfg_data[DATA_WIDTH-2:0];
                    REG_OUT_MIN: omin_reg <= cfg_data;
                    REG_OUT_MAX: omax_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_CLEAR:
                begin
                    integ_reg  <= '0;
                    prev_reg   <= '0;
                    first_reg  <= 1'b1;
                    drive_reg  <= '0;
                    status_reg <= ST_CLEARED;
                end
                OP_SKIP:
                begin
                    first_reg  <= 1'b0;
                    drive_reg  <= '0;
                    status_reg <= ST_NOT_COMPUTED;
                end
                OP_DIV_INIT:
                begin
                    cnt_reg <= CW'(NW);
                end
                OP_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
                OP_SUM:
                begin
                    integ_reg  <= integ_next;
                    prev_reg   <= e_reg;
                    drive_reg  <= s2[DATA_WIDTH-1:0];
                    status_reg <= ST_COMPUTED;
                end
                default: ;
            endcase
        end
    end

    assign integ_next = acc_new_reg[DATA_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            sp_reg <= sp_in;
            fb_reg <= fb_in;
            ff_reg <= ff_in;
            dt_reg <= dt_in;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                e_reg <= EW'(sp_reg) - EW'(fb_reg);
            end
            OP_MUL_P:
            begin
                sum_reg <= ACW'((PW'(gp_reg) * PW'(e_reg)) >>> FRAC_BITS);
            end
            OP_MUL_KI:
            begin
                k_reg <= KW'((DATA_WIDTH+TIME_W+1)'($signed(gi_reg) * $signed({1'b0, dt_reg}))
                             >>> TIME_FRAC);
            end
            OP_MUL_I:
            begin
                // low half of the integral gain times elapsed time, multiplied by the error
                acc_new_reg <= ACW'($signed({1'b0, k_reg[KL-1:0]}) * e_reg);
            end
            OP_MUL_IH:
            begin
                acc_new_reg <= ACW'(integ_reg)
                             + ((acc_new_reg + (ACW'($signed(k_reg[KW-1:KL]) * e_reg) <<< KL))
                                >>> FRAC_BITS);
            end
            OP_CLAMP_I:
            begin
                acc_new_reg <= acc_c;
                sum_reg     <= sum_reg + acc_c;
            end
            OP_MUL_FF:
            begin
                sum_reg <= sum_reg + ACW'((PW'(gf_reg) * PW'(ff_reg)) >>> FRAC_BITS);
            end
            OP_MUL_D:
            begin
                dneg_reg <= dprod[PW-1];
                quo_reg  <= (dprod[PW-1] ? NW'(-dprod) : NW'(dprod)) << (TIME_FRAC - FRAC_BITS);
                rem_reg  <= '0;
            end
            OP_DIV_STEP:
            begin
                if (!trial[TIME_W+1])
                begin
                    rem_reg <= trial[TIME_W:0];
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[TIME_W-1:0], quo_reg[NW-1]};
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign drive  = drive_reg;
    assign status = status_reg;

`ifndef SYNTHESIS
    a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SUM |=> ($signed(integ_reg) <= $signed({1'b0, wl_reg})
                              && $signed(integ_reg) >= -$signed({1'b0, wl_reg})))
        else $error("integral out of windup bounds");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_CLEAR |=> (first_reg && integ_reg == '0 && status_reg == ST_CLEARED))
        else $error("clear did not reset state");
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SKIP |=> (drive_reg == '0 && $stable(integ_reg)))
        else $error("skip changed integral");
`endif
endmodule

[design/pfa_ctrl.sv]
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      mode,
    output logic      in_load,
    output logic      m_tvalid,
    input  logic      m_tready,
    output pfa_cmd_t  cmd,
    input  pfa_stat_t stat
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_MP    = 4'd3;
    localparam logic [3:0] S_KI    = 4'd4;
    localparam logic [3:0] S_MI    = 4'd5;
    localparam logic [3:0] S_CI    = 4'd6;
    localparam logic [3:0] S_FF    = 4'd7;
    localparam logic [3:0] S_MD    = 4'd8;
    localparam logic [3:0] S_DI    = 4'd9;
    localparam logic [3:0] S_DS    = 4'd10;
    localparam logic [3:0] S_SUM   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_MH    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       mode_reg;
    logic       busy;

    assign busy     = state_reg != S_IDLE && !(state_reg == S_OUT && m_tready);
    assign s_tready = !busy;
    assign in_load  = s_tvalid && s_tready;
    assign m_tvalid = state_reg == S_OUT;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                if (in_load)
                begin
                    state_next = S_CHECK;
                end
                else if (state_reg == S_OUT && m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (mode_reg)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_OUT;
                end
                else if (stat.first || stat.dt_small)
                begin
                    cmd.op     = OP_SKIP;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin cmd.op = OP_LOAD;     state_next = S_MP; end
            S_MP:   begin cmd.op = OP_MUL_P;    state_next = S_KI; end
            S_KI:   begin cmd.op = OP_MUL_KI;   state_next = S_MI; end
            S_MI:   begin cmd.op = OP_MUL_I;    state_next = S_MH; end
            S_MH:   begin cmd.op = OP_MUL_IH;   state_next = S_CI; end
            S_CI:   begin cmd.op = OP_CLAMP_I;  state_next = S_FF; end
            S_FF:   begin cmd.op = OP_MUL_FF;   state_next = S_MD; end
            S_MD:   begin cmd.op = OP_MUL_D;    state_next = S_DI; end
            S_DI:   begin cmd.op = OP_DIV_INIT; state_next = S_DS; end
            S_DS:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:  begin cmd.op = OP_SUM;      state_next = S_OUT; end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_load)
            begin
                mode_reg <= mode;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_OUT) |-> !s_tready)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DS && stat.div_last) |=> state_reg == S_SUM)
        else $error("divider sequencing");
`endif
endmodule

[design/pid_feedforward_antiwindup_unit.sv]
// sequence: a clear or skipped item goes from the check state straight to the output state;
// a computed item runs the load, gain, integral, clamp, feedforward and derivative steps, then a
// restoring divider and the final sum; no new item is accepted while one is being computed,
// and the next item is taken in the cycle the current result transfers
// reset: rst_n asynchronous active low; gains 0, windup 3.0, limits -1.0 and 1.0,
// integral and last error 0, first-sample flag set
module pid_feedforward_antiwindup_unit
    import pfa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // setpoint, measured, feedforward_in, elapsed
    input  logic [3*DATA_WIDTH+TIME_W-1:0]   s_tdata,
    // mode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // drive
    output logic [DATA_WIDTH-1:0]            m_tdata,
    // status
    output logic [STATUS_W-1:0]              m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [DATA_WIDTH-1:0]            cfg_data
);
    pfa_cmd_t  cmd;
    pfa_stat_t stat;
    logic      in_load;

    assign cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .in_load  (in_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pfa_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_we   (cfg_valid),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .in_load  (in_load),
        .sp_in    (s_tdata[DATA_WIDTH-1:0]),
        .fb_in    (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .ff_in    (s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .dt_in    (s_tdata[3*DATA_WIDTH+TIME_W-1:3*DATA_WIDTH]),
        .drive    (m_tdata),
        .status   (m_tuser)
    );
endmodule
